FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

FILE: design/sukset_pkg.sv
// Shared types and constants for the sorted unique key set.
// No dependencies.
package sukset_pkg;

  localparam int CAPACITY  = 64;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_W     = 32;
  localparam int OUT_CNT_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

FILE: design/sorted_unique_key_set_unit.sv
// Sorted unique key set: top level, sequencer and key store.
// Depends on sukset_pkg and sukset_ram.
//
// Holds up to CAPACITY distinct signed 32-bit keys in ascending order in a
// single-port-per-direction RAM. A request (in_operation, in_key) is taken
// when start is high and busy is low; busy then stays high until the word's
// result has been issued. Each request yields exactly one result word,
// out_status and out_entry_count, shown for one cycle with out_valid; the
// receiver cannot stall, so capture it on that cycle. A new request may be
// presented in the same cycle the result is shown.
// Steps per operation (P = slot of the first key not below in_key):
//   clear             resets the count
//   lookup            search from slot 0 up to P
//   insert            search, then move the tail from P up
//                     one slot (skipped when appending), then write the key at P
//   delete            search, then move the tail above P down one slot (skipped for the last key)
// One key is compared per cycle during the search and one key is moved per
// cycle during the shift; the RAM's one read and one write port per cycle set
// both figures. No clearing pass: data read from slots beyond the count is never used.
// Status: done/found, duplicate/absent, full. Duplicate is reported before
// full, and a full store leaves the set unchanged.
module sorted_unique_key_set_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic signed [31:0] in_key,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_PLACE,
    S_CLEAR
  } state_t;

  // sequencer state
  state_t                         state_r, state_nxt;
  sukset_pkg::op_t                op_r, op_nxt;
  logic signed [sukset_pkg::KEY_W-1:0] key_r, key_nxt;
  sukset_pkg::cnt_t               count_r, count_nxt;

  // search pipeline: ptr issues a read, cmp_pos tags the data coming back
  sukset_pkg::cnt_t               ptr_r, ptr_nxt;
  sukset_pkg::cnt_t               cmp_pos_r, cmp_pos_nxt;
  logic                           dval_r, dval_nxt;
  sukset_pkg::cnt_t               pos_r, pos_nxt;

  // shift walker: read src, write the previous src's data one slot over
  sukset_pkg::cnt_t               src_r, src_nxt;
  sukset_pkg::cnt_t               prev_src_r, prev_src_nxt;
  sukset_pkg::cnt_t               rem_r, rem_nxt;
  logic                           pend_r, pend_nxt;
  logic                           dir_up_r, dir_up_nxt;   // 1: delete, close gap

  // registered result
  logic                           out_valid_r, out_valid_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;
  logic [sukset_pkg::OUT_CNT_W-1:0] out_count_r, out_count_nxt;

  // RAM port
  logic                           ram_we;
  sukset_pkg::addr_t              ram_wa;
  logic [sukset_pkg::KEY_W-1:0]   ram_wd;
  sukset_pkg::addr_t              ram_ra;
  logic [sukset_pkg::KEY_W-1:0]   ram_rd;

  sukset_ram #(
    .WIDTH (sukset_pkg::KEY_W),
    .DEPTH (sukset_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  always_comb begin
    logic             srch_done;
    logic             srch_hit;
    sukset_pkg::cnt_t srch_pos;
    sukset_pkg::cnt_t moves;
    sukset_pkg::cnt_t wa_full;

    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    cmp_pos_nxt    = cmp_pos_r;
    dval_nxt       = dval_r;
    pos_nxt        = pos_r;
    src_nxt        = src_r;
    prev_src_nxt   = prev_src_r;
    rem_nxt        = rem_r;
    pend_nxt       = pend_r;
    dir_up_nxt     = dir_up_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    ram_we  = 1'b0;
    ram_wa  = pos_r[sukset_pkg::ADDR_W-1:0];
    ram_wd  = ram_rd;
    ram_ra  = ptr_r[sukset_pkg::ADDR_W-1:0];

    srch_done = 1'b0;
    srch_hit  = 1'b0;
    srch_pos  = cmp_pos_r;
    moves     = '0;
    wa_full   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = sukset_pkg::op_t'(in_operation);
          key_nxt  = in_key;
          ptr_nxt  = '0;
          dval_nxt = 1'b0;
          if (sukset_pkg::op_t'(in_operation) == sukset_pkg::OP_CLEAR) begin
            state_nxt = S_CLEAR;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end

      S_CLEAR: begin
        count_nxt      = '0;
        out_valid_nxt  = 1'b1;
        out_status_nxt = sukset_pkg::ST_DONE;
        out_count_nxt  = '0;
        state_nxt      = S_IDLE;
      end

      S_SEARCH: begin
        // stream reads ahead; compare data for cmp_pos_r
        ram_ra      = ptr_r[sukset_pkg::ADDR_W-1:0];
        ptr_nxt     = ptr_r + sukset_pkg::cnt_t'(1);
        cmp_pos_nxt = ptr_r;
        dval_nxt    = 1'b1;
        if (dval_r) begin
          if (cmp_pos_r == count_r) begin
            srch_done = 1'b1;
            srch_hit  = 1'b0;
            srch_pos  = count_r;
          end else if ($signed(ram_rd) >= key_r) begin
            srch_done = 1'b1;
            srch_hit  = (ram_rd == key_r);
            srch_pos  = cmp_pos_r;
          end
        end

        if (srch_done) begin
          pos_nxt = srch_pos;
          case (op_r)
            sukset_pkg::OP_INSERT: begin
              if (srch_hit) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = sukset_pkg::ST_MISS;
                out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r);
                state_nxt      = S_IDLE;
              end else if (count_r >= sukset_pkg::cnt_t'(sukset_pkg::CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = sukset_pkg::ST_FULL;
                out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r);
                state_nxt      = S_IDLE;
              end else begin
                moves = count_r - srch_pos;
                if (moves == '0) begin
                  state_nxt = S_PLACE;
                end else begin
                  src_nxt    = count_r - sukset_pkg::cnt_t'(1);
                  rem_nxt    = moves;
                  pend_nxt   = 1'b0;
                  dir_up_nxt = 1'b0;
                  state_nxt  = S_SHIFT;
                end
              end
            end
            sukset_pkg::OP_DELETE: begin
              if (!srch_hit) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = sukset_pkg::ST_MISS;
                out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r);
                state_nxt      = S_IDLE;
              end else begin
                moves = count_r - srch_pos - sukset_pkg::cnt_t'(1);
                if (moves == '0) begin
                  count_nxt      = count_r - sukset_pkg::cnt_t'(1);
                  out_valid_nxt  = 1'b1;
                  out_status_nxt = sukset_pkg::ST_DONE;
                  out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r - sukset_pkg::cnt_t'(1));
                  state_nxt      = S_IDLE;
                end else begin
                  src_nxt    = srch_pos + sukset_pkg::cnt_t'(1);
                  rem_nxt    = moves;
                  pend_nxt   = 1'b0;
                  dir_up_nxt = 1'b1;
                  state_nxt  = S_SHIFT;
                end
              end
            end
            default: begin
              // lookup
              out_valid_nxt  = 1'b1;
              out_status_nxt = srch_hit ? sukset_pkg::ST_DONE : sukset_pkg::ST_MISS;
              out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r);
              state_nxt      = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        ram_ra = src_r[sukset_pkg::ADDR_W-1:0];
        if (pend_r) begin
          wa_full = dir_up_r ? (prev_src_r - sukset_pkg::cnt_t'(1))
                             : (prev_src_r + sukset_pkg::cnt_t'(1));
          ram_we  = 1'b1;
          ram_wa  = wa_full[sukset_pkg::ADDR_W-1:0];
          ram_wd  = ram_rd;
        end
        if (rem_r != '0) begin
          src_nxt      = dir_up_r ? (src_r + sukset_pkg::cnt_t'(1))
                                  : (src_r - sukset_pkg::cnt_t'(1));
          rem_nxt      = rem_r - sukset_pkg::cnt_t'(1);
          pend_nxt     = 1'b1;
          prev_src_nxt = src_r;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (dir_up_r) begin
              count_nxt      = count_r - sukset_pkg::cnt_t'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = sukset_pkg::ST_DONE;
              out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r - sukset_pkg::cnt_t'(1));
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_PLACE;
            end
          end
        end
      end

      S_PLACE: begin
        ram_we         = 1'b1;
        ram_wa         = pos_r[sukset_pkg::ADDR_W-1:0];
        ram_wd         = $unsigned(key_r);
        count_nxt      = count_r + sukset_pkg::cnt_t'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = sukset_pkg::ST_DONE;
        out_count_nxt  = sukset_pkg::OUT_CNT_W'(count_r + sukset_pkg::cnt_t'(1));
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dval_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      key_r        <= key_nxt;
      count_r      <= count_nxt;
      ptr_r        <= ptr_nxt;
      cmp_pos_r    <= cmp_pos_nxt;
      dval_r       <= dval_nxt;
      pos_r        <= pos_nxt;
      src_r        <= src_nxt;
      prev_src_r   <= prev_src_nxt;
      rem_r        <= rem_nxt;
      pend_r       <= pend_nxt;
      dir_up_r     <= dir_up_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule

FILE: design/sukset_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sukset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/sukset_checker.sv
// Port-level checker for the sorted unique key set, bound to the top level.
// Depends on sukset_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sukset_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [6:0]  out_entry_count
);

  `CHK_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
  `CHK_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held two cycles")
  `CHK_IMPLY(a_status_code, clk, rst_n, out_valid, (out_status == sukset_pkg::ST_DONE || out_status == sukset_pkg::ST_MISS || out_status == sukset_pkg::ST_FULL), "bad status code")
  `CHK_IMPLY(a_full_count, clk, rst_n, out_valid && out_status == sukset_pkg::ST_FULL, (out_entry_count == 7'(sukset_pkg::CAPACITY)), "full reported below capacity")
  `CHK_IMPLY(a_clear_result, clk, rst_n, start && !busy && in_operation == sukset_pkg::OP_CLEAR, ##2 (out_valid && out_entry_count == '0 && out_status == sukset_pkg::ST_DONE), "clear result wrong")

endmodule

bind sorted_unique_key_set_unit sukset_checker u_sukset_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_operation    (in_operation),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);
